// ===== rtl/fnmf_pkg.sv =====
package fnmf_pkg;

	localparam int MAX_COLS    = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;

	// fixed port field widths
	localparam int IN_SAMPLE_W = 16;
	localparam int MEAN_W      = 24;
	localparam int ROW_W       = 16;
	localparam int OUT_COL_W   = 10;
	localparam int COLS_REG_W  = 11;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int COLS_W = $clog2(MAX_COLS + 1);
	localparam int SUM_W  = SAMPLE_BITS + 2;
	localparam int PROD_W = SUM_W + FRAC_BITS;
	localparam int CNT_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_ROWS = 2'd0,
		REG_FRAME_COLS = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} res_ent_t;

endpackage

// ===== rtl/fnmf_sample_if.sv =====
interface fnmf_sample_if;
	import fnmf_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [IN_SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/fnmf_result_if.sv =====
interface fnmf_result_if;
	import fnmf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [MEAN_W-1:0]    mean_value;
	logic [ROW_W-1:0]     out_row;
	logic [OUT_COL_W-1:0] out_col;
	logic                 frame_end;

	modport source (output valid, output mean_value, output out_row, output out_col,
		output frame_end, input ready);
	modport sink (input valid, input mean_value, input out_row, input out_col,
		input frame_end, output ready);
endinterface

// ===== rtl/fnmf_ram.sv =====
module fnmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// read-first; rdata holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule

// ===== rtl/fnmf_mean.sv =====
module fnmf_mean (
	input  logic [fnmf_pkg::SUM_W-1:0]  sum,
	input  logic [fnmf_pkg::CNT_W-1:0]  cnt,
	output logic [fnmf_pkg::PROD_W-1:0] mean
);
	import fnmf_pkg::*;

	// divide by three: multiply by a rounded-up reciprocal, exact for x < 2**PROD_W
	localparam int DIV_SH  = PROD_W + 2;
	localparam int RECIP_W = DIV_SH - 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SH) / 64'd3) + 64'd1);

	logic [PROD_W-1:0]         x;
	logic [PROD_W+RECIP_W-1:0] prod;

	assign x    = {sum, {FRAC_BITS{1'b0}}} >> 0;
	assign prod = (PROD_W+RECIP_W)'(x) * (PROD_W+RECIP_W)'(RECIP);

	always_comb begin
		case (cnt)
			3'd2:    mean = x >> 1;
			3'd3:    mean = PROD_W'(prod >> DIV_SH);
			3'd4:    mean = x >> 2;
			default: mean = x;
		endcase
	end
endmodule

// ===== rtl/four_neighbour_mean_filter_unit.sv =====
// Channel     Dir  Transaction payload
// sample_ch   in   sample
// result_ch   out  mean_value, out_row, out_col, frame_end
// cfg_*       in   write enable, register index, data (no handshake)
//
// Rows before the last: one sample per cycle unless result_ch stalls, one result
// each (none on the first row). Last row: two result transactions per sample (one
// in the first column, three on the final one); the single-result output sequencer
// holds sample_ch.ready low while it issues them. Reset clears counters, valids,
// frame sizes and held samples; line stores need no clearing pass.
// A stalled result_ch backs up through the result slots to sample_ch.ready.
module four_neighbour_mean_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	fnmf_sample_if.sink                       sample_ch,
	fnmf_result_if.source                     result_ch,
	input  logic                              cfg_we,
	input  logic [fnmf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fnmf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fnmf_pkg::*;

	logic [ROW_W-1:0]       rows_q;
	logic [COLS_W-1:0]      cols_q;
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [SAMPLE_BITS-1:0] held_left_q, held_left2_q, held3_q;

	logic                   accept, c_last, r_last;
	logic [SAMPLE_BITS-1:0] s_in, older_rd, newer_rd;
	logic [COL_W-1:0]       rd_addr;
	logic [ROW_W-1:0]       rows_in;
	logic [COLS_REG_W-1:0]  cols_in;

	logic                   v_s1;
	logic [SAMPLE_BITS-1:0] s_s1, mid_s1, hl_s1, hl2_s1, hl3_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [COL_W-1:0]       col_s1;
	logic                   first_row_s1, above_s1, left_s1, left2_s1, right_s1;
	logic                   last_row_s1, c_last_s1;

	res_ent_t               ent_new [3];
	logic [1:0]             n_new;
	res_ent_t               ent_s2 [3];
	logic [1:0]             n_s2, idx_s2;
	res_ent_t               cur;
	logic                   emit, s2_done, s1_adv;

	logic [PROD_W-1:0]      mean_w;
	logic                   out_v_q;
	logic [MEAN_W-1:0]      mean_q;
	logic [ROW_W-1:0]       out_row_q;
	logic [OUT_COL_W-1:0]   out_col_q;
	logic                   frame_end_q;

	assign accept  = sample_ch.valid && sample_ch.ready;
	assign s_in    = SAMPLE_BITS'(sample_ch.sample);
	assign c_last  = (COLS_W'(col_q) + COLS_W'(1)) >= cols_q;
	assign r_last  = ({1'b0, row_q} + (ROW_W+1)'(1)) >= {1'b0, rows_q};
	assign rd_addr = c_last ? '0 : col_q + COL_W'(1);
	assign rows_in = cfg_data[ROW_W-1:0];
	assign cols_in = cfg_data[COLS_REG_W-1:0];

	// older: row r-2 at c, read-first against the write of row r-1
	fnmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS)) u_line_older (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (newer_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (older_rd)
	);

	// newer: read one column ahead; held output is the next sample's upper neighbour
	fnmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS)) u_line_newer (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (s_in),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (newer_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q       <= ROW_W'(2);
			cols_q       <= COLS_W'(2);
			row_q        <= '0;
			col_q        <= '0;
			held_left_q  <= '0;
			held_left2_q <= '0;
			held3_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_ROWS: begin
					rows_q       <= (rows_in < ROW_W'(2)) ? ROW_W'(2) : rows_in;
					row_q        <= '0;
					col_q        <= '0;
					held_left_q  <= '0;
					held_left2_q <= '0;
				end
				REG_FRAME_COLS: begin
					if (cols_in < COLS_REG_W'(2)) begin
						cols_q <= COLS_W'(2);
					end else if (32'(cols_in) > MAX_COLS) begin
						cols_q <= COLS_W'(MAX_COLS);
					end else begin
						cols_q <= COLS_W'(cols_in);
					end
					row_q        <= '0;
					col_q        <= '0;
					held_left_q  <= '0;
					held_left2_q <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			held_left_q  <= newer_rd;
			held_left2_q <= s_in;
			held3_q      <= held_left2_q;
			if (c_last) begin
				col_q <= '0;
				row_q <= r_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_s1         <= s_in;
			mid_s1       <= newer_rd;
			hl_s1        <= held_left_q;
			hl2_s1       <= held_left2_q;
			hl3_s1       <= held3_q;
			row_s1       <= row_q;
			col_s1       <= col_q;
			first_row_s1 <= (row_q == '0);
			above_s1     <= (row_q >= ROW_W'(2));
			left_s1      <= (col_q != '0);
			left2_s1     <= (col_q >= COL_W'(2));
			right_s1     <= !c_last;
			last_row_s1  <= r_last;
			c_last_s1    <= c_last;
		end
	end

	// slot 0: row above; slot 1: last row, column to the left; slot 2: final corner
	always_comb begin
		ent_new[0].sum  = SUM_W'(s_s1)
			+ (above_s1 ? SUM_W'(older_rd) : '0)
			+ (left_s1 ? SUM_W'(hl_s1) : '0)
			+ (right_s1 ? SUM_W'(newer_rd) : '0);
		ent_new[0].cnt  = CNT_W'(1) + CNT_W'(above_s1) + CNT_W'(left_s1) + CNT_W'(right_s1);
		ent_new[0].row  = row_s1 - ROW_W'(1);
		ent_new[0].col  = col_s1;
		ent_new[0].last = 1'b0;

		ent_new[1].sum  = SUM_W'(hl_s1) + SUM_W'(s_s1) + (left2_s1 ? SUM_W'(hl3_s1) : '0);
		ent_new[1].cnt  = CNT_W'(2) + CNT_W'(left2_s1);
		ent_new[1].row  = row_s1;
		ent_new[1].col  = col_s1 - COL_W'(1);
		ent_new[1].last = 1'b0;

		ent_new[2].sum  = SUM_W'(mid_s1) + SUM_W'(hl2_s1);
		ent_new[2].cnt  = CNT_W'(2);
		ent_new[2].row  = row_s1;
		ent_new[2].col  = col_s1;
		ent_new[2].last = 1'b1;

		if (first_row_s1) begin
			n_new = 2'd0;
		end else if (last_row_s1 && left_s1) begin
			n_new = c_last_s1 ? 2'd3 : 2'd2;
		end else begin
			n_new = 2'd1;
		end
	end

	always_comb begin
		case (idx_s2)
			2'd1:    cur = ent_s2[1];
			2'd2:    cur = ent_s2[2];
			default: cur = ent_s2[0];
		endcase
	end

	assign emit    = (n_s2 != 2'd0) && (!out_v_q || result_ch.ready);
	assign s2_done = emit && (idx_s2 == n_s2 - 2'd1);
	assign s1_adv  = v_s1 && ((n_s2 == 2'd0) || s2_done);
	assign sample_ch.ready = !v_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_s2   <= 2'd0;
			idx_s2 <= 2'd0;
		end else if (s1_adv) begin
			n_s2   <= n_new;
			idx_s2 <= 2'd0;
		end else if (s2_done) begin
			n_s2   <= 2'd0;
		end else if (emit) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ent_s2 <= ent_new;
		end
	end

	fnmf_mean u_mean (
		.sum  (cur.sum),
		.cnt  (cur.cnt),
		.mean (mean_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mean_q      <= MEAN_W'(mean_w);
			out_row_q   <= cur.row;
			out_col_q   <= OUT_COL_W'(cur.col);
			frame_end_q <= cur.last;
		end
	end

	assign result_ch.valid      = out_v_q;
	assign result_ch.mean_value = mean_q;
	assign result_ch.out_row    = out_row_q;
	assign result_ch.out_col    = out_col_q;
	assign result_ch.frame_end  = frame_end_q;
endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fnmf_pkg::*;

	localparam int RUN_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 156;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	typedef struct packed {
		logic [MEAN_W-1:0]    mean_value;
		logic [ROW_W-1:0]     out_row;
		logic [OUT_COL_W-1:0] out_col;
		logic                 frame_end;
	} mean_result_t;

	class mean_predictor;
		mean_result_t           pending_means[$];
		bit [SAMPLE_BITS-1:0]   line_older[MAX_COLS];
		bit [SAMPLE_BITS-1:0]   line_newer[MAX_COLS];
		int unsigned            row_pos = 0;
		int unsigned            col_pos = 0;
		bit [SAMPLE_BITS-1:0]   left_above = '0;
		bit [SAMPLE_BITS-1:0]   left_here = '0;
		bit [ROW_W-1:0]         rows_reg = ROW_W'(2);
		bit [COLS_REG_W-1:0]    cols_reg = COLS_REG_W'(2);
		int unsigned            errors = 0;
		int unsigned            reported = 0;

		function void restart_frame();
			row_pos = 0;
			col_pos = 0;
			left_above = '0;
			left_here = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			if (index == REG_FRAME_ROWS) begin
				rows_reg = value[ROW_W-1:0];
				restart_frame();
			end else if (index == REG_FRAME_COLS) begin
				cols_reg = value[COLS_REG_W-1:0];
				restart_frame();
			end
		endfunction

		function void push_mean(longint unsigned total, int unsigned count,
			int unsigned row, int unsigned col, bit last);
			mean_result_t    m;
			longint unsigned q;
			q = (total << FRAC_BITS) / count;
			m.mean_value = q[MEAN_W-1:0];
			m.out_row = row[ROW_W-1:0];
			m.out_col = col[OUT_COL_W-1:0];
			m.frame_end = last;
			pending_means.push_back(m);
		endfunction

		function void take_sample(logic [IN_SAMPLE_W-1:0] value);
			int unsigned          rows;
			int unsigned          cols;
			int unsigned          r;
			int unsigned          c;
			int unsigned          cnt;
			longint unsigned      sum;
			bit [SAMPLE_BITS-1:0] s;
			bit [SAMPLE_BITS-1:0] mid;
			rows = (rows_reg < 2) ? 2 : 32'(rows_reg);
			cols = (cols_reg < 2) ? 2 : (cols_reg > MAX_COLS) ? MAX_COLS : 32'(cols_reg);
			s = value[SAMPLE_BITS-1:0];
			if (row_pos >= rows || col_pos >= cols)
				restart_frame();
			r = row_pos;
			c = col_pos;
			mid = line_newer[c];
			if (r >= 1) begin
				// row above: current sample lies below it
				sum = 64'(s);
				cnt = 1;
				if (r > 1) begin
					sum += 64'(line_older[c]);
					cnt++;
				end
				if (c > 0) begin
					sum += 64'(left_above);
					cnt++;
				end
				if (c + 1 < cols) begin
					sum += 64'(line_newer[c + 1]);
					cnt++;
				end
				push_mean(sum, cnt, r - 1, c, 1'b0);
			end
			if (r == rows - 1 && c >= 1) begin
				sum = 64'(left_above);
				sum += 64'(s);
				cnt = 2;
				if (c >= 2) begin
					sum += 64'(line_newer[c - 2]);
					cnt++;
				end
				push_mean(sum, cnt, r, c - 1, 1'b0);
				if (c == cols - 1) begin
					sum = 64'(mid);
					sum += 64'(left_here);
					push_mean(sum, 2, r, c, 1'b1);
				end
			end
			line_older[c] = mid;
			line_newer[c] = s;
			left_above = mid;
			left_here = s;
			if (c + 1 >= cols) begin
				col_pos = 0;
				row_pos = (r + 1 >= rows) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void match_mean(mean_result_t got);
			mean_result_t want;
			if (pending_means.size() == 0) begin
				errors++;
				if (reported < 100) begin
					reported++;
					$display("%0t ns: unexpected result mean %h row %0d col %0d end %0b",
						$time, got.mean_value, got.out_row, got.out_col, got.frame_end);
				end
			end else begin
				want = pending_means.pop_front();
				if (got !== want) begin
					errors++;
					if (reported < 100) begin
						reported++;
						$display("%0t ns: expected mean %h row %0d col %0d end %0b",
							$time, want.mean_value, want.out_row, want.out_col,
							want.frame_end);
						$display("%0t ns:   actual mean %h row %0d col %0d end %0b",
							$time, got.mean_value, got.out_row, got.out_col,
							got.frame_end);
					end
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fnmf_sample_if sample_ch();
	fnmf_result_if result_ch();

	four_neighbour_mean_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mean_predictor board;
	bit            calm = 1'b0;
	int            stall_left = 0;
	int            cycle_count = 0;
	mean_result_t  seen;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic int pick_gap();
		int k;
		if (calm)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 16);
	endfunction

	function automatic logic [IN_SAMPLE_W-1:0] pick_sample();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return '0;
		if (k == 1)
			return '1;
		return IN_SAMPLE_W'($urandom_range(0, 65535));
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			result_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// one transaction per accepted result
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen.mean_value = result_ch.mean_value;
			seen.out_row = result_ch.out_row;
			seen.out_col = result_ch.out_col;
			seen.frame_end = result_ch.frame_end;
			board.match_mean(seen);
		end
	end

	task automatic send_sample(input logic [IN_SAMPLE_W-1:0] value);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= value;
		do @(posedge clk); while (!sample_ch.ready);
		board.take_sample(value);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_sample(pick_sample());
	endtask

	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (board.pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		board.write_reg(index, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [IN_SAMPLE_W-1:0] mix[9];
		int                     random_sent;
		int                     mode;
		int                     frames;
		int                     len;
		int                     rows_eff;
		int                     cols_eff;
		logic [CFG_DATA_W-1:0]  rows_data;
		logic [CFG_DATA_W-1:0]  cols_data;
		bit                     paused;

		mix = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
		board = new;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset sizes, 2x2
		calm = 1'b1;
		repeat (4) send_sample(16'hFFFF);
		drain_results();
		calm = 1'b0;

		// rows and columns below 2 act as 2
		write_reg(REG_FRAME_ROWS, 16'd1);
		write_reg(REG_FRAME_COLS, 16'd0);
		send_random(4);
		drain_results();

		write_reg(REG_FRAME_ROWS, 16'd3);
		write_reg(REG_FRAME_COLS, 16'd3);
		foreach (mix[i])
			send_sample(mix[i]);
		drain_results();

		// unused indexes mid-frame: frame must carry on
		send_random(3);
		drain_results();
		write_reg(REG_UNUSED_A, 16'd7);
		write_reg(REG_UNUSED_B, 16'hFFFF);
		send_random(6);
		drain_results();

		// column data masked to 11 bits, then clamped to the line depth
		write_reg(REG_FRAME_ROWS, 16'd3);
		write_reg(REG_FRAME_COLS, 16'hFFFF);
		send_random(8);
		drain_results();

		write_reg(REG_FRAME_ROWS, 16'hFFFF);
		write_reg(REG_FRAME_COLS, 16'd2);
		send_random(8);
		drain_results();

		write_reg(REG_FRAME_ROWS, 16'd2);
		write_reg(REG_FRAME_COLS, 16'hF803);
		send_random(12);
		drain_results();

		rows_eff = 2;
		cols_eff = 3;
		random_sent = 0;
		paused = 1'b0;
		while (random_sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 19))
				0: rows_data = CFG_DATA_W'($urandom_range(0, 1));
				default: rows_data = CFG_DATA_W'($urandom_range(2, 5));
			endcase
			case ($urandom_range(0, 9))
				0: cols_data = CFG_DATA_W'($urandom_range(0, 1));
				1: cols_data = CFG_DATA_W'(($urandom_range(1, 31) << COLS_REG_W)
					| $urandom_range(2, 8));
				default: cols_data = CFG_DATA_W'($urandom_range(2, 8));
			endcase
			mode = $urandom_range(0, 9);
			if (mode == 0)
				write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
					CFG_DATA_W'($urandom_range(0, 65535)));
			if (mode == 1 || mode >= 3) begin
				write_reg(REG_FRAME_ROWS, rows_data);
				rows_eff = (rows_data < 2) ? 2 : int'(rows_data);
			end
			if (mode >= 2) begin
				write_reg(REG_FRAME_COLS, cols_data);
				cols_eff = int'(cols_data[COLS_REG_W-1:0]);
				if (cols_eff < 2)
					cols_eff = 2;
				if (cols_eff > MAX_COLS)
					cols_eff = MAX_COLS;
			end
			frames = $urandom_range(1, 3);
			repeat (frames) begin
				len = rows_eff * cols_eff;
				if ($urandom_range(0, 6) == 0)
					len = $urandom_range(1, len - 1);
				if (len > RANDOM_ITEMS - random_sent)
					len = RANDOM_ITEMS - random_sent;
				for (int i = 0; i < len; i++) begin
					if (!paused && i == len / 2 && i > cols_eff) begin
						drain_results();
						paused = 1'b1;
					end
					send_sample(pick_sample());
					random_sent++;
				end
			end
			drain_results();
		end

		calm = 1'b0;
		drain_results();
		if (board.errors == 0 && board.pending_means.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== four_neighbour_mean_filter_unit.f =====
rtl/fnmf_pkg.sv
rtl/fnmf_sample_if.sv
rtl/fnmf_result_if.sv
rtl/fnmf_ram.sv
rtl/fnmf_mean.sv
rtl/four_neighbour_mean_filter_unit.sv
test/testbench.sv
